[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Both sample on clk and are off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every edge out of reset.
`define QRGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define QRGS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/qrgs_pkg.sv]
package qrgs_pkg;

  localparam int MAX_ROWS_DEF = 4;
  localparam int MAX_COLS_DEF = 4;
  localparam int CFG_W        = 3;
  localparam int ELEM_W       = 16;
  localparam int VAL_W        = 32;

  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_NRD,
    S_NMUL,
    S_NACC,
    S_SQRT,
    S_DIAG,
    S_QRD,
    S_QDIV,
    S_QWAIT,
    S_QWR,
    S_RRD,
    S_RMUL,
    S_RACC,
    S_RWR,
    S_URD,
    S_UMUL,
    S_UWR,
    S_ORD,
    S_OLD,
    S_OWAIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      r = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  // Division by 65536 with truncation toward zero.
  function automatic logic signed [47:0] div65536(input logic signed [63:0] x);
    logic signed [47:0] t;
    t = $signed(x[63:16]);
    if (x[63] && (x[15:0] != 16'd0)) begin
      t = t + 48'sd1;
    end
    return t;
  endfunction

endpackage

[hw/rtl/qr_decomposition_gram_schmidt_unit.sv]
// QR factorization of an m-by-n matrix (m, n up to MAX_ROWS, MAX_COLS; n is
// clamped to m) by modified Gram-Schmidt in fixed point. Elements enter in
// row-major order, one word per cycle, as Q7.8. After the last element the
// block factors the matrix and then emits Q (m by n) and R (n by n, zeros below
// the diagonal included), row-major, as saturated Q15.16 words, with last set
// on the final R word. No input is taken from the last element until the final
// word of the job has been taken. The working matrix, Q and R sit in
// single-port-read memories and every step reads, computes and writes back.
// Per column k the block accumulates the squared norm, takes the bit-pair
// square root and stores the diagonal, runs the 48-step restoring divider
// for each row to form Q's column unless the diagonal is zero, and projects
// and updates each later column; output then follows and can be stalled.
`include "assert_macros.svh"

module qr_decomposition_gram_schmidt_unit #(
  parameter int MAX_ROWS = qrgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = qrgs_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [0:0]                        cfg_index,
  input  logic [qrgs_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [qrgs_pkg::ELEM_W-1:0] element,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qrgs_pkg::VAL_W-1:0] value,
  output logic                              which_matrix,
  output logic [1:0]                        row_index,
  output logic [1:0]                        col_index,
  output logic                              degenerate,
  output logic                              last
);

  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IW    = (RIW > CIW) ? RIW : CIW;
  localparam int WDEP  = MAX_ROWS * MAX_COLS;
  localparam int RDEP  = MAX_COLS * MAX_COLS;
  localparam int WAW   = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int RAW   = (RDEP > 1) ? $clog2(RDEP) : 1;

  qrgs_pkg::state_t state, state_next;

  logic [qrgs_pkg::CFG_W-1:0] rows_in_use, cols_in_use;
  logic [IW-1:0] m_last, n_last;
  logic [IW-1:0] i, j, k;
  logic [IW-1:0] o_row, o_col;
  logic          o_phase;
  logic          degen;

  // Memories: working columns, Q and R.
  logic signed [31:0] work_mem [WDEP];
  logic signed [31:0] q_mem    [WDEP];
  logic signed [31:0] r_mem    [RDEP];
  logic signed [31:0] w_rdata, q_rdata, r_rdata;
  logic [WAW-1:0]     w_raddr, w_waddr, q_raddr, q_waddr;
  logic [RAW-1:0]     r_raddr, r_waddr;
  logic               w_we, q_we, r_we;
  logic signed [31:0] w_wdata, q_wdata, r_wdata;

  // Datapath registers.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [63:0]        norm;
  logic signed [63:0] acc;
  logic signed [31:0] rkk, rkj, w_hold;
  logic [63:0]        sq_x;
  logic [33:0]        sq_rem;
  logic [31:0]        sq_root;
  logic [4:0]         sq_cnt;
  logic [47:0]        dv_q;
  logic [31:0]        dv_rem;
  logic               dv_neg;
  logic [5:0]         dv_cnt;

  logic               in_fire, out_fire;
  logic               i_end, j_end, k_end;

  // Combinational helpers.
  logic [64:0]        norm_sum;
  logic [63:0]        norm_next;
  logic [35:0]        sq_sh, sq_trial;
  logic               sq_ge;
  logic [32:0]        dv_t;
  logic               dv_ge;
  logic [32:0]        w_abs;
  logic signed [31:0] rkk_c, rkj_c, q_val, upd_val;

  function automatic logic [WAW-1:0] w_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return WAW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  function automatic logic [RAW-1:0] r_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return RAW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // Effective dimensions, clamped.
  always_comb begin
    int m_int;
    int n_int;
    m_int = int'(rows_in_use);
    if (m_int < 1) m_int = 1;
    if (m_int > MAX_ROWS) m_int = MAX_ROWS;
    n_int = int'(cols_in_use);
    if (n_int < 1) n_int = 1;
    if (n_int > MAX_COLS) n_int = MAX_COLS;
    if (n_int > m_int) n_int = m_int;
    m_last = IW'(m_int - 1);
    n_last = IW'(n_int - 1);
  end

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign i_end    = (i == m_last);
  assign j_end    = (j == n_last);
  assign k_end    = (k == n_last);

  // Arithmetic steps.
  always_comb begin
    norm_sum  = {1'b0, norm} + {1'b0, prod};
    norm_next = norm_sum[64] ? '1 : norm_sum[63:0];
    sq_sh     = {sq_rem, sq_x[63:62]};
    sq_trial  = {2'b00, sq_root, 2'b01};
    sq_ge     = (sq_sh >= sq_trial);
    dv_t      = {dv_rem, dv_q[47]};
    dv_ge     = (dv_t >= {1'b0, rkk});
    w_abs     = w_rdata[31] ? -{w_rdata[31], w_rdata} : {1'b0, w_rdata};
    rkk_c     = sq_root[31] ? 32'sh7FFF_FFFF : $signed(sq_root);
    rkj_c     = qrgs_pkg::sat32(64'(qrgs_pkg::div65536(acc)));
    q_val     = qrgs_pkg::sat32(dv_neg ? -$signed({16'd0, dv_q}) : $signed({16'd0, dv_q}));
    upd_val   = qrgs_pkg::sat32(64'(w_hold) - 64'(qrgs_pkg::div65536(prod)));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      qrgs_pkg::S_LOAD: begin
        if (!cfg_write && in_fire && i_end && j_end) state_next = qrgs_pkg::S_NRD;
      end
      qrgs_pkg::S_NRD:  state_next = qrgs_pkg::S_NMUL;
      qrgs_pkg::S_NMUL: state_next = qrgs_pkg::S_NACC;
      qrgs_pkg::S_NACC: state_next = i_end ? qrgs_pkg::S_SQRT : qrgs_pkg::S_NRD;
      qrgs_pkg::S_SQRT: begin
        if (sq_cnt == 5'd0) state_next = qrgs_pkg::S_DIAG;
      end
      qrgs_pkg::S_DIAG: state_next = qrgs_pkg::S_QRD;
      qrgs_pkg::S_QRD:  state_next = qrgs_pkg::S_QDIV;
      qrgs_pkg::S_QDIV: state_next = (rkk == 32'sd0) ? qrgs_pkg::S_QWR : qrgs_pkg::S_QWAIT;
      qrgs_pkg::S_QWAIT: begin
        if (dv_cnt == 6'd0) state_next = qrgs_pkg::S_QWR;
      end
      qrgs_pkg::S_QWR: begin
        if (!i_end) state_next = qrgs_pkg::S_QRD;
        else if (k_end) state_next = qrgs_pkg::S_ORD;
        else state_next = qrgs_pkg::S_RRD;
      end
      qrgs_pkg::S_RRD:  state_next = qrgs_pkg::S_RMUL;
      qrgs_pkg::S_RMUL: state_next = qrgs_pkg::S_RACC;
      qrgs_pkg::S_RACC: state_next = i_end ? qrgs_pkg::S_RWR : qrgs_pkg::S_RRD;
      qrgs_pkg::S_RWR:  state_next = qrgs_pkg::S_URD;
      qrgs_pkg::S_URD:  state_next = qrgs_pkg::S_UMUL;
      qrgs_pkg::S_UMUL: state_next = qrgs_pkg::S_UWR;
      qrgs_pkg::S_UWR: begin
        if (!i_end) state_next = qrgs_pkg::S_URD;
        else if (j_end) state_next = qrgs_pkg::S_NRD;
        else state_next = qrgs_pkg::S_RRD;
      end
      qrgs_pkg::S_ORD:  state_next = qrgs_pkg::S_OLD;
      qrgs_pkg::S_OLD:  state_next = qrgs_pkg::S_OWAIT;
      qrgs_pkg::S_OWAIT: begin
        if (out_ready) begin
          if (o_phase && (o_row == n_last) && (o_col == n_last)) begin
            state_next = qrgs_pkg::S_LOAD;
          end else begin
            state_next = qrgs_pkg::S_ORD;
          end
        end
      end
      default: state_next = qrgs_pkg::S_LOAD;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    in_ready = 1'b0;
    w_raddr  = w_addr(i, j);
    w_waddr  = w_addr(i, j);
    w_wdata  = upd_val;
    w_we     = 1'b0;
    q_raddr  = w_addr(i, k);
    q_waddr  = w_addr(i, k);
    q_wdata  = q_val;
    q_we     = 1'b0;
    r_raddr  = r_addr(o_row, o_col);
    r_waddr  = r_addr(k, j);
    r_wdata  = rkj_c;
    r_we     = 1'b0;
    mul_a    = w_rdata;
    mul_b    = w_rdata;
    unique case (state)
      qrgs_pkg::S_LOAD: begin
        in_ready = 1'b1;
        w_wdata  = 32'(element) <<< 8;
        w_we     = in_fire && !cfg_write;
      end
      qrgs_pkg::S_NRD, qrgs_pkg::S_QRD: w_raddr = w_addr(i, k);
      qrgs_pkg::S_DIAG: begin
        r_waddr = r_addr(k, k);
        r_wdata = rkk_c;
        r_we    = 1'b1;
      end
      qrgs_pkg::S_QWR:  q_we = 1'b1;
      qrgs_pkg::S_RMUL: mul_a = q_rdata;
      qrgs_pkg::S_RWR:  r_we = 1'b1;
      qrgs_pkg::S_UMUL: begin
        mul_a = rkj;
        mul_b = q_rdata;
      end
      qrgs_pkg::S_UWR:  w_we = 1'b1;
      qrgs_pkg::S_ORD:  q_raddr = w_addr(o_row, o_col);
      default: begin
      end
    endcase
  end

  // Memories with registered read data. A read of an entry in the cycle it is
  // written returns the old value; the sequencer uses no such read data.
  always_ff @(posedge clk) begin
    if (w_we) work_mem[w_waddr] <= w_wdata;
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (r_we) r_mem[r_waddr] <= r_wdata;
    w_rdata <= work_mem[w_raddr];
    q_rdata <= q_mem[q_raddr];
    r_rdata <= r_mem[r_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= qrgs_pkg::S_LOAD;
      rows_in_use <= qrgs_pkg::CFG_W'(4);
      cols_in_use <= qrgs_pkg::CFG_W'(4);
      i           <= '0;
      j           <= '0;
      k           <= '0;
      o_row       <= '0;
      o_col       <= '0;
      o_phase     <= 1'b0;
      degen       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        qrgs_pkg::S_LOAD: begin
          if (cfg_write) begin
            if (cfg_index == qrgs_pkg::REG_ROWS) rows_in_use <= cfg_data;
            else cols_in_use <= cfg_data;
            i <= '0;
            j <= '0;
          end else if (in_fire) begin
            if (j_end) begin
              j <= '0;
              i <= i_end ? '0 : i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
            if (i_end && j_end) begin
              k     <= '0;
              degen <= 1'b0;
            end
          end
        end
        qrgs_pkg::S_NACC, qrgs_pkg::S_RACC: i <= i_end ? '0 : i + 1'b1;
        qrgs_pkg::S_DIAG: begin
          if (rkk_c == 32'sd0) degen <= 1'b1;
        end
        qrgs_pkg::S_QWR: begin
          i <= i_end ? '0 : i + 1'b1;
          if (i_end) begin
            // After the last column the load counters must start from zero.
            j       <= k_end ? '0 : k + 1'b1;
            o_row   <= '0;
            o_col   <= '0;
            o_phase <= 1'b0;
          end
        end
        qrgs_pkg::S_UWR: begin
          i <= i_end ? '0 : i + 1'b1;
          if (i_end) begin
            if (j_end) k <= k + 1'b1;
            else j <= j + 1'b1;
          end
        end
        qrgs_pkg::S_OLD: out_valid <= 1'b1;
        qrgs_pkg::S_OWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (o_col == n_last) begin
              o_col <= '0;
              if (!o_phase && (o_row == m_last)) begin
                o_phase <= 1'b1;
                o_row   <= '0;
              end else begin
                o_row <= o_row + 1'b1;
              end
            end else begin
              o_col <= o_col + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      qrgs_pkg::S_LOAD: norm <= '0;
      qrgs_pkg::S_NMUL, qrgs_pkg::S_RMUL, qrgs_pkg::S_UMUL: begin
        prod <= mul_a * mul_b;
        if (state == qrgs_pkg::S_UMUL) w_hold <= w_rdata;
      end
      qrgs_pkg::S_NACC: begin
        norm <= norm_next;
        if (i_end) begin
          sq_x    <= norm_next;
          sq_rem  <= '0;
          sq_root <= '0;
          sq_cnt  <= 5'd31;
        end
      end
      qrgs_pkg::S_SQRT: begin
        sq_x    <= {sq_x[61:0], 2'b00};
        sq_rem  <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
        sq_root <= {sq_root[30:0], sq_ge};
        sq_cnt  <= sq_cnt - 1'b1;
      end
      qrgs_pkg::S_DIAG: rkk <= rkk_c;
      qrgs_pkg::S_QDIV: begin
        dv_rem <= '0;
        dv_cnt <= 6'd47;
        if (rkk == 32'sd0) begin
          dv_q   <= '0;
          dv_neg <= 1'b0;
        end else begin
          dv_q   <= {w_abs[31:0], 16'd0};
          dv_neg <= w_rdata[31];
        end
      end
      qrgs_pkg::S_QWAIT: begin
        dv_rem <= dv_ge ? 32'(dv_t - {1'b0, rkk}) : dv_t[31:0];
        dv_q   <= {dv_q[46:0], dv_ge};
        dv_cnt <= dv_cnt - 1'b1;
      end
      qrgs_pkg::S_QWR: acc <= '0;
      qrgs_pkg::S_RACC: acc <= qrgs_pkg::sat_add64(acc, prod);
      qrgs_pkg::S_RWR: rkj <= rkj_c;
      qrgs_pkg::S_UWR: begin
        acc <= '0;
        if (i_end && j_end) norm <= '0;
      end
      qrgs_pkg::S_OLD: begin
        if (o_phase) value <= (o_col < o_row) ? 32'sd0 : r_rdata;
        else value <= q_rdata;
        which_matrix <= o_phase;
        row_index    <= 2'(o_row);
        col_index    <= 2'(o_col);
        degenerate   <= degen;
        last         <= o_phase && (o_row == n_last) && (o_col == n_last);
      end
      default: begin
      end
    endcase
  end

  `QRGS_ASSERT(a_load_xor_emit, !(in_ready && out_valid), "input taken while a result is shown")
  `QRGS_ASSERT_IMPL(a_last_on_r, out_valid && last, which_matrix, "last mark on a Q word")
  `QRGS_ASSERT_IMPL(a_div_nonzero, state == qrgs_pkg::S_QWAIT, rkk != 32'sd0, "divide by zero norm")

endmodule

[bench/qr_decomposition_gram_schmidt_unit_tb.sv]
module qr_decomposition_gram_schmidt_unit_tb;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int ITEM_GOAL = 210;

  typedef struct packed {
    logic [31:0] value;
    logic        which_matrix;
    logic [1:0]  row_index;
    logic [1:0]  col_index;
    logic        degenerate;
    logic        last;
  } qr_word_t;

  class qr_scoreboard;
    int unsigned rows_reg = 4;
    int unsigned cols_reg = 4;
    int unsigned fill = 0;
    logic signed [31:0] a_mat [4][4];
    logic signed [31:0] q_mat [4][4];
    logic signed [31:0] r_mat [4][4];
    bit degen_flag = 0;
    qr_word_t pending [$];
    int errors = 0;

    function int unsigned rows_eff();
      int unsigned m;
      m = rows_reg;
      if (m < 1) m = 1;
      if (m > 4) m = 4;
      return m;
    endfunction

    function int unsigned cols_eff();
      int unsigned n;
      n = cols_reg;
      if (n < 1) n = 1;
      if (n > 4) n = 4;
      if (n > rows_eff()) n = rows_eff();
      return n;
    endfunction

    function logic signed [31:0] clip32(longint x);
      if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    function longint add_clip64(longint x, longint y);
      if (y > 0 && x > 64'sh7FFF_FFFF_FFFF_FFFF - y) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (y < 0 && x < 64'sh8000_0000_0000_0000 - y) return 64'sh8000_0000_0000_0000;
      return x + y;
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void write_reg(qrgs_pkg::reg_index_t idx, int unsigned val);
      if (idx == qrgs_pkg::REG_ROWS) rows_reg = val & 7;
      else cols_reg = val & 7;
      fill = 0;
    endfunction

    function void factor_matrix(int unsigned m, int unsigned n);
      longint unsigned norm2, sq, av, root;
      longint acc, corr;
      logic signed [31:0] rkk, rkj;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) r_mat[i][j] = 0;
      degen_flag = 0;
      for (int k = 0; k < n; k++) begin
        norm2 = 0;
        for (int i = 0; i < m; i++) begin
          av = (a_mat[i][k] < 0) ? -longint'(a_mat[i][k]) : longint'(a_mat[i][k]);
          sq = av * av;
          norm2 = (norm2 > ~64'd0 - sq) ? ~64'd0 : norm2 + sq;
        end
        root = floor_root(norm2);
        rkk = (root > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : root[31:0];
        r_mat[k][k] = rkk;
        if (rkk == 0) degen_flag = 1;
        for (int i = 0; i < m; i++)
          q_mat[i][k] = (rkk == 0) ? 32'sd0
                        : clip32((longint'(a_mat[i][k]) * 65536) / longint'(rkk));
        for (int j = k + 1; j < n; j++) begin
          acc = 0;
          for (int i = 0; i < m; i++)
            acc = add_clip64(acc, longint'(q_mat[i][k]) * longint'(a_mat[i][j]));
          rkj = clip32(acc / 65536);
          r_mat[k][j] = rkj;
          for (int i = 0; i < m; i++) begin
            corr = (longint'(rkj) * longint'(q_mat[i][k])) / 65536;
            a_mat[i][j] = clip32(longint'(a_mat[i][j]) - corr);
          end
        end
      end
    endfunction

    function void note_element(logic signed [15:0] elem);
      int unsigned m, n;
      qr_word_t w;
      m = rows_eff();
      n = cols_eff();
      if (fill >= m * n) fill = 0;
      a_mat[fill / n][fill % n] = int'(elem) * 256;
      fill++;
      if (fill < m * n) return;
      fill = 0;
      factor_matrix(m, n);
      for (int i = 0; i < m; i++)
        for (int j = 0; j < n; j++) begin
          w = '{q_mat[i][j], 1'b0, i[1:0], j[1:0], degen_flag, 1'b0};
          pending.push_back(w);
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          w = '{r_mat[i][j], 1'b1, i[1:0], j[1:0], degen_flag, (i == n - 1 && j == n - 1)};
          pending.push_back(w);
        end
    endfunction

    function void check_word(qr_word_t got);
      qr_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word: value %h mat %0d row %0d col %0d", $time,
                 got.value, got.which_matrix, got.row_index, got.col_index);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mismatch: expected value %h mat %0d row %0d col %0d degen %0d last %0d",
                 $time, exp_w.value, exp_w.which_matrix, exp_w.row_index, exp_w.col_index,
                 exp_w.degenerate, exp_w.last);
        $display("%0t:           actual value %h mat %0d row %0d col %0d degen %0d last %0d",
                 $time, got.value, got.which_matrix, got.row_index, got.col_index,
                 got.degenerate, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [0:0] cfg_index = 0;
  logic [qrgs_pkg::CFG_W-1:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [qrgs_pkg::ELEM_W-1:0] element = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [qrgs_pkg::VAL_W-1:0] value;
  logic which_matrix;
  logic [1:0] row_index;
  logic [1:0] col_index;
  logic degenerate;
  logic last;

  qr_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  bit calm = 0;
  bit squeeze = 0;

  qr_decomposition_gram_schmidt_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: signals are sampled at the edge before any update from it.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_word('{value, which_matrix, row_index, col_index, degenerate, last});
      if (squeeze) begin
        squeeze = 0;
        // Long enough to outlast the factoring of the first job.
        hold = 4000;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  task automatic send_element(logic signed [15:0] x);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    element <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_element(x);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(qrgs_pkg::reg_index_t idx, int unsigned val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val[qrgs_pkg::CFG_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_write <= 0;
  endtask

  // One whole matrix in one of several shapes: random, small, with a zero
  // column, with a repeated column (zero after projection), or extreme values.
  task automatic send_job(int unsigned m, int unsigned n, int unsigned kind);
    logic signed [15:0] mat [16];
    int zc;
    logic signed [15:0] picks [5];
    picks = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF};
    zc = $urandom_range(0, n - 1);
    for (int i = 0; i < m * n; i++) begin
      case (kind)
        1: mat[i] = $urandom_range(0, 1024) - 512;
        4: mat[i] = picks[$urandom_range(0, 4)];
        default: mat[i] = $urandom;
      endcase
      if (kind == 2 && i % n == zc) mat[i] = 0;
      if (kind == 3 && n > 1 && i % n == n - 1) mat[i] = mat[i - (n - 1)];
    end
    for (int i = 0; i < m * n; i++) send_element(mat[i]);
  endtask

  initial begin
    int unsigned rv, cv, m, n, jobs;
    bit first;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_reg(qrgs_pkg::REG_ROWS, 1);
    write_reg(qrgs_pkg::REG_COLS, 1);
    send_element(16'sh0000);
    send_element(16'sh7FFF);
    send_element(16'sh8000);
    send_element(16'sh0001);
    drain();
    write_reg(qrgs_pkg::REG_ROWS, 2);
    write_reg(qrgs_pkg::REG_COLS, 2);
    send_element(16'sh7FFF);
    send_element(16'sh7FFF);
    send_element(16'sh8000);
    send_element(16'sh8000);
    drain();
    // A partial matrix is thrown away by the next register write.
    send_element(16'sh1234);
    send_element(16'shFEDC);
    send_element(16'sh0100);
    drain();
    write_reg(qrgs_pkg::REG_ROWS, 0);
    write_reg(qrgs_pkg::REG_COLS, 7);
    send_element(16'shFF00);
    drain();
    write_reg(qrgs_pkg::REG_ROWS, 7);
    write_reg(qrgs_pkg::REG_COLS, 4);
    send_job(4, 4, 2);
    drain();

    first = 1;
    while (sent < ITEM_GOAL) begin
      rv = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 7) : $urandom_range(1, 3);
      cv = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 7) : $urandom_range(1, 3);
      if ($urandom_range(0, 3) != 0 || first) write_reg(qrgs_pkg::REG_ROWS, rv);
      write_reg(qrgs_pkg::REG_COLS, cv);
      m = sb.rows_eff();
      n = sb.cols_eff();
      jobs = first ? 3 : $urandom_range(1, 3);
      if (first) squeeze = 1;
      calm = (sent > 90 && sent < 140);
      for (int k = 0; k < jobs; k++) send_job(m, n, $urandom_range(0, 5));
      if ($urandom_range(0, 4) == 0 && m * n > 1)
        for (int k = 0; k < $urandom_range(1, m * n - 1); k++) send_element($urandom);
      drain();
      first = 0;
    end
    calm = 0;
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/qrgs_pkg.sv
hw/rtl/qr_decomposition_gram_schmidt_unit.sv
bench/qr_decomposition_gram_schmidt_unit_tb.sv
